// ----- hdl/itt_pkg.sv -----
package itt_pkg;

	localparam int CHANNELS = 3;

	localparam logic [1:0] MARK_STATUS = 2'd1;
	localparam logic [1:0] MARK_COUNT  = 2'd2;
	localparam logic [7:0] BYTE_ONES   = 8'hFF;

	typedef enum logic [1:0] {
		K_WRITE   = 2'd0,
		K_READ    = 2'd1,
		K_TICK    = 2'd2,
		K_SPEAKER = 2'd3
	} kind_t;

	localparam logic [1:0] PORT_CTRL = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] port;
		logic [7:0] wdata;
	} item_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       irq_pulse;
		logic [2:0] out_levels;
	} result_t;

	typedef struct packed {
		logic [16:0] reload;
		logic [16:0] ph;
		logic [7:0]  low_hold;
		logic [1:0]  acc;
		logic [1:0]  rstep;
		logic [1:0]  wstep;
		logic [2:0]  cmode;
		logic        bcd;
		logic [7:0]  status;
		logic [3:0]  marks;
		logic [15:0] chold;
	} chan_t;

	function automatic logic [15:0] live_count(input chan_t c);
		logic [16:0] d;
		d = c.reload - c.ph;
		if (c.reload == 17'd0 || c.ph == 17'd0)
			return 16'd0;
		return d[15:0];
	endfunction

	function automatic logic out_level(input chan_t c);
		logic [16:0] h;
		logic lv;
		h = 17'd0;
		lv = 1'b0;
		if (c.reload != 17'd0) begin
			unique case (c.cmode)
				3'd0: lv = 1'b1;
				3'd1: lv = 1'b0;
				3'd2, 3'd6: lv = (c.ph != 17'd1);
				3'd3, 3'd7: begin
					if (c.reload[0]) begin
						h = (c.reload >> 1) + 17'd1;
						lv = (c.ph >= h);
					end else begin
						h = (c.reload - 17'd1) >> 1;
						lv = (c.ph < h);
					end
				end
				default: lv = (c.ph != 17'd0);
			endcase
		end
		return lv;
	endfunction

endpackage

// ----- hdl/itt_stream_if.sv -----
interface itt_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/interval_timer_three_channel.sv -----
// Three-channel 8254-style interval timer. Every input word (port write, port
// read, counter tick, speaker read) yields exactly one result word. One word is
// accepted per cycle: the item is applied to the channel registers in the
// accept cycle and its result enters a two-entry output register/skid stage,
// so input ready drops only when both entries are full. No BCD and no gates.
module interval_timer_three_channel
	import itt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	itt_stream_if.sink   in_ch,
	itt_stream_if.source out_ch
);

	chan_t   ch_q [3];
	chan_t   ch_n [3];
	logic    irq_run_q, irq_run_n;
	logic [15:0] prev_q, prev_n;
	logic    spk_q, spk_n;

	result_t out_q, skid_q, res;
	logic    out_v_q, skid_v_q;
	item_t   it;
	logic    acc_in;

	assign it = item_t'(in_ch.data);
	assign in_ch.ready = !skid_v_q;
	assign acc_in = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;

	always_comb begin
		logic [1:0] pc, op_acc;
		logic [2:0] op;
		logic [15:0] ct, v;
		logic [7:0] rd;
		logic irq;
		for (int i = 0; i < 3; i++) ch_n[i] = ch_q[i];
		irq_run_n = irq_run_q;
		prev_n = prev_q;
		spk_n = spk_q;
		rd = 8'd0;
		irq = 1'b0;
		pc = it.wdata[7:6];
		op = it.wdata[3:1];
		op_acc = it.wdata[5:4];
		ct = 16'd0;
		v = 16'd0;
		unique case (kind_t'(it.mode))
			K_WRITE: begin
				if (it.port != PORT_CTRL) begin
					for (int i = 0; i < 3; i++) begin
						if (it.port == 2'(i) && i < CHANNELS) begin
							logic ld;
							ld = 1'b1;
							unique case (ch_q[i].wstep)
								2'd0: v = {8'd0, it.wdata};
								2'd1: v = {it.wdata, 8'd0};
								2'd2: begin
									ld = 1'b0;
									ch_n[i].low_hold = it.wdata;
									ch_n[i].wstep = 2'd3;
								end
								default: begin
									v = {it.wdata, ch_q[i].low_hold};
									ch_n[i].wstep = 2'd2;
								end
							endcase
							if (ld) begin
								ch_n[i].reload = (v == 16'd0) ? 17'h10000 : {1'b0, v};
								ch_n[i].ph = 17'd0;
								if (i == 0) begin
									irq_run_n = 1'b1;
									prev_n = 16'd0;
								end
							end
						end
					end
				end else begin
					for (int i = 0; i < 3; i++) begin
						logic sel;
						sel = (pc == 2'd3) ? op[i] : (pc == 2'(i) && op_acc == 2'd0);
						if (i < CHANNELS && sel) begin
							if (!op_acc[1] && !ch_q[i].marks[1]) begin
								ct = live_count(ch_q[i]);
								ch_n[i].marks = {ch_q[i].acc, MARK_COUNT[1],
									ch_q[i].marks[0]};
								unique case (ch_q[i].acc)
									2'd1: ch_n[i].chold = {8'd0, ct[7:0]};
									2'd2: ch_n[i].chold = {8'd0, ct[15:8]};
									2'd3: ch_n[i].chold = ct;
									default: ;
								endcase
							end
							if (pc == 2'd3 && !op_acc[0] && !ch_q[i].marks[0]) begin
								ch_n[i].status = {out_level(ch_q[i]), 1'b0, ch_q[i].acc,
									ch_q[i].cmode, ch_q[i].bcd};
								ch_n[i].marks[0] = 1'b1;
							end
						end
						if (i < CHANNELS && pc == 2'(i) && op_acc != 2'd0) begin
							ch_n[i].acc = op_acc;
							ch_n[i].wstep = op_acc - 2'd1;
							ch_n[i].rstep = op_acc - 2'd1;
							ch_n[i].cmode = op;
							ch_n[i].bcd = it.wdata[0];
							if (i == 0 && op[1:0] == 2'd2) irq = 1'b1;
						end
					end
				end
			end
			K_READ: begin
				rd = BYTE_ONES;
				for (int i = 0; i < 3; i++) begin
					if (it.port == 2'(i) && i < CHANNELS) begin
						if (ch_q[i].marks[0]) begin
							ch_n[i].marks[0] = 1'b0;
							rd = ch_q[i].status;
						end else if (ch_q[i].marks[1]) begin
							unique case (ch_q[i].marks[3:2])
								2'd1, 2'd2: begin
									ch_n[i].marks = 4'd0;
									rd = ch_q[i].chold[7:0];
								end
								2'd3: begin
									ch_n[i].marks = {2'd2, MARK_COUNT};
									rd = ch_q[i].chold[7:0];
									ch_n[i].chold = {8'd0, ch_q[i].chold[15:8]};
								end
								default: begin
									ch_n[i].marks = 4'd0;
									rd = BYTE_ONES;
								end
							endcase
						end else begin
							ct = live_count(ch_q[i]);
							unique case (ch_q[i].rstep)
								2'd0: rd = ct[7:0];
								2'd1: rd = ct[15:8];
								2'd2: begin
									rd = ct[7:0];
									ch_n[i].rstep = 2'd3;
								end
								default: begin
									rd = ct[15:8];
									ch_n[i].rstep = 2'd2;
								end
							endcase
						end
					end
				end
			end
			K_TICK: begin
				for (int i = 0; i < 3; i++) begin
					if (i < CHANNELS && ch_q[i].reload != 17'd0) begin
						ch_n[i].ph = (ch_q[i].ph + 17'd1 >= ch_q[i].reload) ? 17'd0
							: ch_q[i].ph + 17'd1;
					end
				end
				if (irq_run_q) begin
					ct = live_count(ch_n[0]);
					if (ct > prev_q) begin
						irq = 1'b1;
						if (!ch_q[0].cmode[1]) irq_run_n = 1'b0;
						else prev_n = ct;
					end else begin
						prev_n = ct;
					end
				end
			end
			default: begin
				spk_n = !spk_q;
				rd = {2'd0, (CHANNELS > 2) ? out_level(ch_q[2]) : 1'b0, !spk_q, 4'd0};
			end
		endcase
		res.rdata = rd;
		res.irq_pulse = irq;
		for (int i = 0; i < 3; i++)
			res.out_levels[i] = (i < CHANNELS) ? out_level(ch_n[i]) : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) ch_q[i] <= '0;
			irq_run_q <= 1'b0;
			prev_q <= 16'd0;
			spk_q <= 1'b0;
		end else if (acc_in) begin
			for (int i = 0; i < 3; i++) ch_q[i] <= ch_n[i];
			irq_run_q <= irq_run_n;
			prev_q <= prev_n;
			spk_q <= spk_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || out_ch.ready) begin
				out_v_q <= skid_v_q || acc_in;
				skid_v_q <= 1'b0;
			end else if (acc_in) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ch.ready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (acc_in) begin
			skid_q <= res;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q) else $error("skid full while output empty");
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !in_ch.ready) else $error("accept while skid full");
	a_irq_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && it.mode == K_TICK && !irq_run_q) |-> !res.irq_pulse)
		else $error("tick irq while not running");
	a_out_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ch.ready) |=> (out_v_q && $stable(out_q)))
		else $error("result lost while stalled");

endmodule

// ----- bench/itt_checker.sv -----
`timescale 1ns / 100ps
module itt_checker
	import itt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [11:0] in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [11:0] out_data,
	output int          fails,
	output int          pending
);

	logic [16:0] reload [3];
	logic [16:0] ph [3];
	logic [7:0]  low_hold [3];
	logic [1:0]  acc [3];
	logic [1:0]  rstep [3];
	logic [1:0]  wstep [3];
	logic [2:0]  cmode [3];
	logic        bcd [3];
	logic [7:0]  status [3];
	logic [3:0]  marks [3];
	logic [15:0] chold [3];
	logic        irq_on;
	logic [15:0] prev_count;
	logic        spk;
	result_t     expected_words[$];

	assign pending = expected_words.size();

	function automatic logic [15:0] count_of(int c);
		logic [16:0] d;
		d = reload[c] - ph[c];
		if (reload[c] == 0 || ph[c] == 0)
			return 16'd0;
		return d[15:0];
	endfunction

	function automatic logic level_of(int c);
		logic [16:0] r;
		logic [16:0] p;
		r = reload[c];
		p = ph[c];
		if (r == 0)
			return 1'b0;
		case (cmode[c])
			3'd0: return 1'b1;
			3'd1: return 1'b0;
			3'd2, 3'd6: return p != 1;
			3'd3, 3'd7: begin
				if (r[0])
					return p >= ((r + 1) >> 1);
				return p < ((r - 1) >> 1);
			end
			default: return p != 0;
		endcase
	endfunction

	function automatic void hold_count(int c);
		logic [15:0] ct;
		if (marks[c][1])
			return;
		ct = count_of(c);
		marks[c] = {acc[c], MARK_COUNT | (marks[c][1:0] & MARK_STATUS)};
		case (acc[c])
			2'd1: chold[c] = {8'd0, ct[7:0]};
			2'd2: chold[c] = {8'd0, ct[15:8]};
			2'd3: chold[c] = ct;
			default: ;
		endcase
	endfunction

	function automatic void load(int c, logic [15:0] v);
		reload[c] = (v == 0) ? 17'h10000 : {1'b0, v};
		ph[c] = 0;
		if (c == 0) begin
			irq_on = 1'b1;
			prev_count = 0;
		end
	endfunction

	function automatic void reset_state();
		for (int c = 0; c < 3; c++) begin
			reload[c] = 0; ph[c] = 0; low_hold[c] = 0; acc[c] = 0; rstep[c] = 0;
			wstep[c] = 0; cmode[c] = 0; bcd[c] = 0; status[c] = 0; marks[c] = 0;
			chold[c] = 0;
		end
		irq_on = 0;
		prev_count = 0;
		spk = 0;
	endfunction

	function automatic logic write_byte(logic [1:0] port, logic [7:0] v);
		int c;
		logic [2:0] op;
		logic [1:0] a;
		if (port != PORT_CTRL) begin
			c = int'(port);
			case (wstep[c])
				2'd0: load(c, {8'd0, v});
				2'd1: load(c, {v, 8'd0});
				2'd2: begin
					low_hold[c] = v;
					wstep[c] = 2'd3;
				end
				default: begin
					load(c, {v, low_hold[c]});
					wstep[c] = 2'd2;
				end
			endcase
			return 1'b0;
		end
		c = int'(v[7:6]);
		op = v[3:1];
		a = v[5:4];
		if (c == 3) begin
			for (int i = 0; i < 3; i++) begin
				if (!op[i])
					continue;
				if (!a[1])
					hold_count(i);
				if (!a[0] && !marks[i][0]) begin
					status[i] = {level_of(i), 1'b0, acc[i], cmode[i], bcd[i]};
					marks[i][0] = 1'b1;
				end
			end
			return 1'b0;
		end
		if (a == 0) begin
			hold_count(c);
			return 1'b0;
		end
		acc[c] = a;
		wstep[c] = a - 2'd1;
		rstep[c] = a - 2'd1;
		cmode[c] = op;
		bcd[c] = v[0];
		return c == 0 && (op == 2 || op == 6);
	endfunction

	function automatic logic [7:0] read_byte(logic [1:0] port);
		int c;
		logic [7:0] r;
		logic [15:0] ct;
		if (port == PORT_CTRL)
			return BYTE_ONES;
		c = int'(port);
		if (marks[c][0]) begin
			marks[c][0] = 1'b0;
			return status[c];
		end
		if (marks[c][1]) begin
			case (marks[c][3:2])
				2'd1, 2'd2: begin
					marks[c] = 0;
					return chold[c][7:0];
				end
				2'd3: begin
					marks[c] = {2'd2, MARK_COUNT};
					r = chold[c][7:0];
					chold[c] = chold[c] >> 8;
					return r;
				end
				default: begin
					marks[c] = 0;
					return BYTE_ONES;
				end
			endcase
		end
		ct = count_of(c);
		case (rstep[c])
			2'd0: return ct[7:0];
			2'd1: return ct[15:8];
			2'd2: begin
				rstep[c] = 2'd3;
				return ct[7:0];
			end
			default: begin
				rstep[c] = 2'd2;
				return ct[15:8];
			end
		endcase
	endfunction

	function automatic logic advance();
		logic [15:0] ct;
		logic p;
		p = 1'b0;
		for (int c = 0; c < 3; c++) begin
			if (reload[c] == 0)
				continue;
			ph[c] = ph[c] + 17'd1;
			if (ph[c] >= reload[c])
				ph[c] = 0;
		end
		if (!irq_on)
			return 1'b0;
		ct = count_of(0);
		if (ct > prev_count) begin
			p = 1'b1;
			if (!(cmode[0] inside {3'd2, 3'd3, 3'd6, 3'd7})) begin
				irq_on = 1'b0;
				return p;
			end
		end
		prev_count = ct;
		return p;
	endfunction

	function automatic result_t timer_result(item_t it);
		result_t r;
		r = '0;
		case (kind_t'(it.mode))
			K_WRITE: r.irq_pulse = write_byte(it.port, it.wdata);
			K_READ: r.rdata = read_byte(it.port);
			K_TICK: r.irq_pulse = advance();
			default: begin
				spk = ~spk;
				r.rdata = {2'b00, level_of(2), spk, 4'd0};
			end
		endcase
		r.out_levels = {level_of(2), level_of(1), level_of(0)};
		return r;
	endfunction

	task automatic report(string what, logic [7:0] got, logic [7:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			reset_state();
			expected_words.delete();
			fails = 0;
		end else begin
			if (in_valid && in_ready)
				expected_words.push_back(timer_result(item_t'(in_data)));
			if (out_valid && out_ready) begin
				got = result_t'(out_data);
				if (expected_words.size() == 0) begin
					$display("unexpected result word at %0t", $realtime);
					fails++;
				end else begin
					want = expected_words.pop_front();
					if (got.rdata !== want.rdata)
						report("rdata", got.rdata, want.rdata);
					if (got.irq_pulse !== want.irq_pulse)
						report("irq_pulse", {7'd0, got.irq_pulse}, {7'd0, want.irq_pulse});
					if (got.out_levels !== want.out_levels)
						report("out_levels", {5'd0, got.out_levels},
							{5'd0, want.out_levels});
				end
			end
		end
	end

endmodule

// ----- bench/interval_timer_three_channel_test.sv -----
`timescale 1ns / 100ps
module interval_timer_three_channel_test;
	import itt_pkg::*;

	localparam int IDLE_LIMIT = 5000;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   idle_cycles = 0;
	int   burst_left;
	logic [15:0] stall_mask = 16'hFFFF;
	int   stall_age = 0;

	itt_stream_if #(.W(12)) word_in();
	itt_stream_if #(.W(12)) word_out();

	interval_timer_three_channel dut (
		.clk(clk), .arst_n(arst_n), .in_ch(word_in.sink), .out_ch(word_out.source)
	);

	itt_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(word_in.valid), .in_ready(word_in.ready), .in_data(word_in.data),
		.out_valid(word_out.valid), .out_ready(word_out.ready), .out_data(word_out.data),
		.fails(fails), .pending(pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// receiver stall pattern, replaced now and then
	always @(posedge clk) begin
		if (stall_age == 0) begin
			stall_age <= $urandom_range(200, 20);
			case ($urandom_range(3, 0))
				0: stall_mask <= 16'hFFFF;
				1: stall_mask <= 16'h0001;
				default: stall_mask <= 16'($urandom);
			endcase
		end else begin
			stall_age <= stall_age - 1;
			stall_mask <= {stall_mask[14:0], stall_mask[15]};
		end
		word_out.ready <= stall_mask[0];
	end

	always @(posedge clk) begin
		if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send(kind_t k, logic [1:0] p, logic [7:0] v);
		item_t it;
		it.mode = k;
		it.port = p;
		it.wdata = v;
		word_in.valid <= 1'b1;
		word_in.data <= it;
		@(posedge clk);
		while (!word_in.ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(40, 0);
			if ($urandom_range(1, 0)) begin
				word_in.valid <= 1'b0;
				repeat ($urandom_range(6, 1)) @(posedge clk);
			end
		end
	endtask

	task automatic random_item();
		int r;
		logic [1:0] c;
		r = $urandom_range(99, 0);
		c = 2'($urandom_range(2, 0));
		if (r < 40)
			send(K_TICK, 2'($urandom), 8'($urandom));
		else if (r < 55)
			send(K_READ, 2'($urandom), 8'($urandom));
		else if (r < 67)
			send(K_WRITE, c, ($urandom_range(3, 0) == 0) ? 8'($urandom)
				: 8'($urandom_range(12, 0)));
		else if (r < 72)
			send(K_WRITE, c, 8'd0);
		else if (r < 87)
			send(K_WRITE, PORT_CTRL, 8'($urandom));
		else if (r < 92)
			send(K_WRITE, PORT_CTRL, {2'b11, 2'($urandom), 4'($urandom)});
		else
			send(K_SPEAKER, 2'($urandom), 8'($urandom));
	endtask

	initial begin
		word_in.valid = 1'b0;
		word_in.data = '0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// latch with access kind still zero
		send(K_WRITE, PORT_CTRL, 8'h80);
		send(K_READ, 2'd2, 8'h00);
		send(K_WRITE, PORT_CTRL, 8'h34);
		send(K_WRITE, 2'd0, 8'h05);
		send(K_WRITE, 2'd0, 8'h00);
		repeat (4) send(K_TICK, 2'd0, 8'h00);
		send(K_READ, 2'd0, 8'h00);
		send(K_READ, 2'd0, 8'h00);
		send(K_WRITE, PORT_CTRL, 8'hE2);
		send(K_WRITE, PORT_CTRL, 8'h00);
		send(K_READ, 2'd0, 8'h00);
		send(K_READ, 2'd0, 8'h00);
		send(K_READ, 2'd0, 8'h00);
		send(K_WRITE, PORT_CTRL, 8'h56);
		send(K_WRITE, 2'd1, 8'h00);
		send(K_WRITE, PORT_CTRL, 8'hB6);
		send(K_WRITE, 2'd2, 8'hFF);
		send(K_WRITE, 2'd2, 8'hFF);
		send(K_WRITE, PORT_CTRL, 8'hCE);
		send(K_READ, 2'd2, 8'h00);
		send(K_READ, PORT_CTRL, 8'h00);
		send(K_SPEAKER, 2'd0, 8'h00);
		send(K_WRITE, PORT_CTRL, 8'h12);
		for (int n = 0; n < 1800; n++)
			random_item();
		word_in.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/itt_pkg.sv
hdl/itt_stream_if.sv
hdl/interval_timer_three_channel.sv
bench/itt_checker.sv
bench/interval_timer_three_channel_test.sv
